// ----- rtl/core/sltseq_pkg.sv -----
`default_nettype none

package sltseq_pkg;

	localparam int PHASE_W  = 7;
	localparam int SLOT_W   = PHASE_W - 2;
	localparam int PULSE_W  = 16;
	localparam int LIMIT_W  = 16;
	localparam int CREDIT_W = 8;
	localparam int SEC_W    = 8;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_DOWN_LIMIT        = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_WATCHDOG_CREDIT_RELOAD = 2'd1;

	localparam logic [LIMIT_W-1:0]  AUTO_DOWN_LIMIT_RST = 16'd14400;
	localparam logic [CREDIT_W-1:0] CREDIT_RELOAD_RST   = 8'd10;
	localparam logic [CREDIT_W-1:0] CREDIT_RST          = 8'd10;

	// 0.1 s slots that mark the one- and two-second boundaries (40 Hz tick / 4)
	localparam logic [SLOT_W-1:0] SLOT_ONE_SEC = 5'd10;
	localparam logic [SLOT_W-1:0] SLOT_TWO_SEC = 5'd20;

	typedef struct packed {
		logic                is_down;
		logic                auto_down_mode;
		logic [LIMIT_W-1:0]  auto_down_elapsed;
		logic [PULSE_W-1:0]  pulse_count_now;
		logic                watchdog_reload;
	} tick_t;

endpackage

`default_nettype wire

// ----- rtl/core/status_led_tick_sequencer_top.sv -----
`default_nettype none

// Status LED tick sequencer. Each input transaction is one 40 Hz tick; each
// tick yields exactly one result transaction carrying the green LED level, the
// watchdog kick, the pulse count latched at the last one-second boundary and a
// wrapping seconds count. A tick is registered on entry and its result in the
// output register as the output advances; one tick is taken every cycle unless
// the output stalls, with a single pass of counter and compare logic between
// the input and output registers. The two-second LED pattern is chosen every
// fourth tick from the phase counter and the status flags. Configuration
// writes take effect at once and are meant to be issued while the block is idle.
module status_led_tick_sequencer_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_wr_en,
	input  wire [sltseq_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire [sltseq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire                                 is_down,
	input  wire                                 auto_down_mode,
	input  wire [sltseq_pkg::LIMIT_W-1:0]       auto_down_elapsed,
	input  wire [sltseq_pkg::PULSE_W-1:0]       pulse_count_now,
	input  wire                                 watchdog_reload,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic                                led_green,
	output logic                                watchdog_kick,
	output logic [sltseq_pkg::PULSE_W-1:0]      pulse_snapshot,
	output logic [sltseq_pkg::SEC_W-1:0]        seconds_count
);
	import sltseq_pkg::*;

	logic [LIMIT_W-1:0]  limit_q;
	logic [CREDIT_W-1:0] reload_q;

	logic                tick_valid_s1;
	tick_t               tick_s1;

	logic [PHASE_W-1:0]  phase_q;
	logic                led_hold_q;
	logic [PULSE_W-1:0]  last_pulse_q;
	logic [PULSE_W-1:0]  pulse_latch_q;
	logic [SEC_W-1:0]    second_q;
	logic [CREDIT_W-1:0] credit_q;

	logic                out_valid_q;
	logic                led_q;
	logic                kick_q;

	logic                advance;
	logic                manual_down, auto_up, wait_done, waiting;
	logic [CREDIT_W-1:0] credit_base, credit_d;
	logic                kick_d;
	logic [PHASE_W-1:0]  phase_inc, phase_d;
	logic [SLOT_W-1:0]   slot;
	logic                led_hold_d;
	logic                latch_en;
	logic                led_d;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !tick_valid_s1 || advance;

	always_comb begin
		manual_down = !tick_s1.auto_down_mode && tick_s1.is_down;
		auto_up     = tick_s1.auto_down_mode && !tick_s1.is_down;
		wait_done   = auto_up && (tick_s1.auto_down_elapsed == limit_q);
		waiting     = auto_up && (tick_s1.auto_down_elapsed < limit_q);

		// reload before the kick
		credit_base = tick_s1.watchdog_reload ? reload_q : credit_q;
		kick_d      = (credit_base != '0);
		credit_d    = kick_d ? credit_base - 1'b1 : credit_base;

		phase_inc  = phase_q + 1'b1;
		slot       = phase_inc[PHASE_W-1:2];
		phase_d    = phase_inc;
		led_hold_d = led_hold_q;
		latch_en   = 1'b0;

		if (phase_inc[1:0] == 2'b00) begin
			case (slot) inside
				5'd1, 5'd5, 5'd7, 5'd9:
					led_hold_d = manual_down;
				5'd3:
					led_hold_d = manual_down || waiting;
				5'd2, 5'd4, 5'd6, 5'd8:
					led_hold_d = manual_down || wait_done;
				5'd12, 5'd14, 5'd16, 5'd18:
					led_hold_d = wait_done;
				5'd11, 5'd13, 5'd15, 5'd17, 5'd19:
					led_hold_d = 1'b0;
				SLOT_ONE_SEC: begin
					led_hold_d = wait_done;
					latch_en   = 1'b1;
				end
				SLOT_TWO_SEC: begin
					phase_d    = '0;
					led_hold_d = tick_s1.is_down || tick_s1.auto_down_mode;
					latch_en   = 1'b1;
				end
				default: ;
			endcase
		end

		// invert for this tick on a pulse while down
		led_d = led_hold_d ^ ((tick_s1.pulse_count_now != last_pulse_q) && tick_s1.is_down);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= AUTO_DOWN_LIMIT_RST;
			reload_q <= CREDIT_RELOAD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_AUTO_DOWN_LIMIT:        limit_q  <= cfg_wdata[LIMIT_W-1:0];
				CFG_WATCHDOG_CREDIT_RELOAD: reload_q <= cfg_wdata[CREDIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			tick_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1 <= '{is_down: is_down, auto_down_mode: auto_down_mode,
				auto_down_elapsed: auto_down_elapsed, pulse_count_now: pulse_count_now,
				watchdog_reload: watchdog_reload};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			led_hold_q    <= 1'b0;
			last_pulse_q  <= '0;
			pulse_latch_q <= '0;
			second_q      <= '0;
			credit_q      <= CREDIT_RST;
			out_valid_q   <= 1'b0;
		end else if (advance) begin
			out_valid_q <= tick_valid_s1;
			if (tick_valid_s1) begin
				phase_q      <= phase_d;
				led_hold_q   <= led_hold_d;
				last_pulse_q <= tick_s1.pulse_count_now;
				credit_q     <= credit_d;
				if (latch_en) begin
					pulse_latch_q <= last_pulse_q;
					second_q      <= second_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tick_valid_s1) begin
			led_q  <= led_d;
			kick_q <= kick_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign led_green      = led_q;
	assign watchdog_kick  = kick_q;
	assign pulse_snapshot = pulse_latch_q;
	assign seconds_count  = second_q;

endmodule

`default_nettype wire

// ----- dv/tb_status_led_tick_sequencer_top.sv -----
`timescale 1ns / 1ps

module tb_status_led_tick_sequencer_top;
	import sltseq_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int RX_HOLD     = 120;
	localparam int IDLE_PCT    = 11;

	typedef struct packed {
		logic                led;
		logic                kick;
		logic [PULSE_W-1:0]  snapshot;
		logic [SEC_W-1:0]    seconds;
	} tick_status_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = CFG_AUTO_DOWN_LIMIT;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	tick_t                 drv_tick = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  led_green;
	logic                  watchdog_kick;
	logic [PULSE_W-1:0]    pulse_snapshot;
	logic [SEC_W-1:0]      seconds_count;

	// sequencer state mirrored for prediction
	logic [PHASE_W-1:0]  phase_q;
	logic                led_hold_q;
	logic [PULSE_W-1:0]  last_pulses_q;
	logic [PULSE_W-1:0]  snapshot_q;
	logic [SEC_W-1:0]    seconds_q;
	logic [CREDIT_W-1:0] credit_q;
	logic [LIMIT_W-1:0]  limit_cfg;
	logic [CREDIT_W-1:0] reload_cfg;

	tick_t        pending_ticks[$];
	tick_status_t status_due[$];

	int  fail_count = 0;
	int  ticks_taken = 0;
	int  results_checked = 0;
	int  kicks_seen = 0;
	int  led_on_seen = 0;
	int  settings_run = 0;
	int  quiet_cycles = 0;
	int  stall_requests = 0;
	int  stalls_served = 0;
	int  rx_hold_left = 0;
	bit  no_idle = 1'b0;
	logic [PULSE_W-1:0] pulse_src = '0;

	status_led_tick_sequencer_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.is_down          (drv_tick.is_down),
		.auto_down_mode   (drv_tick.auto_down_mode),
		.auto_down_elapsed(drv_tick.auto_down_elapsed),
		.pulse_count_now  (drv_tick.pulse_count_now),
		.watchdog_reload  (drv_tick.watchdog_reload),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.led_green        (led_green),
		.watchdog_kick    (watchdog_kick),
		.pulse_snapshot   (pulse_snapshot),
		.seconds_count    (seconds_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		fail_count++;
		$display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	function automatic tick_status_t advance_sequencer(input tick_t t);
		tick_status_t       r;
		logic               manual_down;
		logic               auto_up;
		logic               wait_done;
		logic               waiting;
		logic [SLOT_W-1:0]  slot;
		manual_down = !t.auto_down_mode && t.is_down;
		auto_up     = t.auto_down_mode && !t.is_down;
		wait_done   = auto_up && (t.auto_down_elapsed == limit_cfg);
		waiting     = auto_up && (t.auto_down_elapsed < limit_cfg);
		r = '0;
		if (t.watchdog_reload)
			credit_q = reload_cfg;
		phase_q = phase_q + 1'b1;
		if (credit_q != '0) begin
			r.kick = 1'b1;
			credit_q = credit_q - 1'b1;
		end
		if (phase_q[1:0] == 2'b00) begin
			slot = phase_q[PHASE_W-1:2];
			case (slot)
				1, 5, 7, 9:         led_hold_q = manual_down;
				3:                  led_hold_q = manual_down || waiting;
				2, 4, 6, 8:         led_hold_q = manual_down || wait_done;
				12, 14, 16, 18:     led_hold_q = wait_done;
				11, 13, 15, 17, 19: led_hold_q = 1'b0;
				SLOT_ONE_SEC: begin
					snapshot_q = last_pulses_q;
					seconds_q  = seconds_q + 1'b1;
					led_hold_q = wait_done;
				end
				SLOT_TWO_SEC: begin
					phase_q    = '0;
					led_hold_q = t.is_down || t.auto_down_mode;
					snapshot_q = last_pulses_q;
					seconds_q  = seconds_q + 1'b1;
				end
				// out-of-pattern slots leave the held bit alone
				default: ;
			endcase
		end
		r.led = led_hold_q;
		if (t.pulse_count_now != last_pulses_q) begin
			// invert for this tick only when down
			if (t.is_down)
				r.led = !r.led;
			last_pulses_q = t.pulse_count_now;
		end
		r.snapshot = snapshot_q;
		r.seconds  = seconds_q;
		return r;
	endfunction

	// sender: hold the transaction until it is taken, then offer the next one
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid) begin
				status_due.push_back(advance_sequencer(drv_tick));
				ticks_taken++;
			end
			if (pending_ticks.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				drv_tick <= pending_ticks.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: check each transaction against the oldest prediction
	always @(posedge clk) begin
		tick_status_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (status_due.size() == 0) begin
					flag_mismatch("unexpected result", seconds_count, 0);
				end else begin
					want = status_due.pop_front();
					if (led_green !== want.led)
						flag_mismatch("led_green", led_green, want.led);
					if (watchdog_kick !== want.kick)
						flag_mismatch("watchdog_kick", watchdog_kick, want.kick);
					if (pulse_snapshot !== want.snapshot)
						flag_mismatch("pulse_snapshot", pulse_snapshot, want.snapshot);
					if (seconds_count !== want.seconds)
						flag_mismatch("seconds_count", seconds_count, want.seconds);
					results_checked++;
					kicks_seen  += want.kick;
					led_on_seen += want.led;
				end
			end
			if (stalls_served < stall_requests) begin
				stalls_served <= stalls_served + 1;
				rx_hold_left  <= RX_HOLD;
				out_ready     <= 1'b0;
			end else if (rx_hold_left != 0) begin
				rx_hold_left <= rx_hold_left - 1;
				out_ready    <= 1'b0;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_ticks.size() != 0 || in_valid || status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		if (idx == CFG_AUTO_DOWN_LIMIT)
			limit_cfg = val[LIMIT_W-1:0];
		else if (idx == CFG_WATCHDOG_CREDIT_RELOAD)
			reload_cfg = val[CREDIT_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_limits(input logic [LIMIT_W-1:0] lim, input logic [CREDIT_W-1:0] rld);
		wait_idle();
		write_reg(CFG_AUTO_DOWN_LIMIT, CFG_DATA_W'(lim));
		write_reg(CFG_WATCHDOG_CREDIT_RELOAD, CFG_DATA_W'(rld));
		settings_run++;
	endtask

	function automatic tick_t mk_tick(input logic dn, input logic au, input logic [LIMIT_W-1:0] el,
			input logic [PULSE_W-1:0] pc, input logic rl);
		tick_t t;
		t.is_down           = dn;
		t.auto_down_mode    = au;
		t.auto_down_elapsed = el;
		t.pulse_count_now   = pc;
		t.watchdog_reload   = rl;
		return t;
	endfunction

	// hold the flags mostly steady over runs so blink patterns play out
	task automatic queue_episodes(input int n);
		tick_t t;
		int    left;
		int    run;
		int    k;
		int    pick;
		logic  dn;
		logic  au;
		left = n;
		while (left > 0) begin
			dn  = 1'($urandom_range(1));
			au  = 1'($urandom_range(1));
			run = $urandom_range(20, 120);
			for (k = 0; k < run && left > 0; k++) begin
				t.is_down        = dn;
				t.auto_down_mode = au;
				if ($urandom_range(99) < 5)
					t.is_down = !dn;
				if ($urandom_range(99) < 5)
					t.auto_down_mode = !au;
				pick = $urandom_range(3);
				case (pick)
					0:       t.auto_down_elapsed = limit_cfg;
					1:       t.auto_down_elapsed = limit_cfg - LIMIT_W'($urandom_range(1, 3));
					2:       t.auto_down_elapsed = limit_cfg + LIMIT_W'($urandom_range(1, 3));
					default: t.auto_down_elapsed = LIMIT_W'($urandom);
				endcase
				pick = $urandom_range(99);
				if (pick >= 90)
					pulse_src = PULSE_W'($urandom);
				else if (pick >= 65)
					pulse_src = pulse_src + 1'b1;
				t.pulse_count_now = pulse_src;
				t.watchdog_reload = ($urandom_range(99) < 6);
				pending_ticks.push_back(t);
				left--;
			end
		end
	endtask

	initial begin
		phase_q       = '0;
		led_hold_q    = 1'b0;
		last_pulses_q = '0;
		snapshot_q    = '0;
		seconds_q     = '0;
		credit_q      = CREDIT_RST;
		limit_cfg     = AUTO_DOWN_LIMIT_RST;
		reload_cfg    = CREDIT_RELOAD_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: flag combinations, field extremes, pulse edges, credit running dry
		set_limits(AUTO_DOWN_LIMIT_RST, CREDIT_RELOAD_RST);
		pending_ticks.push_back(mk_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0));
		pending_ticks.push_back(mk_tick(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0));
		pending_ticks.push_back(mk_tick(1'b0, 1'b1, limit_cfg, 16'hFFFF, 1'b0));
		pending_ticks.push_back(mk_tick(1'b0, 1'b1, 16'h0000, 16'hFFFF, 1'b1));
		pending_ticks.push_back(mk_tick(1'b0, 1'b1, 16'hFFFF, 16'h0000, 1'b0));
		pending_ticks.push_back(mk_tick(1'b1, 1'b1, limit_cfg, 16'h0000, 1'b0));
		pending_ticks.push_back(mk_tick(1'b1, 1'b1, 16'h5555, 16'hAAAA, 1'b0));
		pending_ticks.push_back(mk_tick(1'b0, 1'b0, 16'hAAAA, 16'h5555, 1'b0));
		pending_ticks.push_back(mk_tick(1'b1, 1'b0, limit_cfg - 1'b1, 16'h5555, 1'b0));
		pending_ticks.push_back(mk_tick(1'b0, 1'b1, limit_cfg - 1'b1, 16'h5555, 1'b0));
		pending_ticks.push_back(mk_tick(1'b0, 1'b1, limit_cfg + 1'b1, 16'h5555, 1'b0));
		pending_ticks.push_back(mk_tick(1'b0, 1'b1, limit_cfg, 16'h5555, 1'b0));
		for (int i = 0; i < 8; i++)
			pending_ticks.push_back(mk_tick(1'b1, 1'b0, 16'h1234, 16'h5556 + i[15:0], 1'b0));
		pending_ticks.push_back(mk_tick(1'b0, 1'b1, limit_cfg, 16'h555D, 1'b1));
		pulse_src = 16'h555D;

		// register extremes, a long receiver hold-off, a stretch with no idling
		set_limits('0, '1);
		queue_episodes(200);
		stall_requests++;

		set_limits('1, '0);
		queue_episodes(150);

		set_limits(LIMIT_W'($urandom), 8'd1);
		no_idle = 1'b1;
		queue_episodes(200);

		set_limits(LIMIT_W'($urandom_range(0, 200)), CREDIT_W'($urandom_range(2, 40)));
		no_idle = 1'b0;
		queue_episodes(200);

		set_limits(AUTO_DOWN_LIMIT_RST, CREDIT_RELOAD_RST);
		queue_episodes(180);
		stall_requests++;

		wait_idle();
		repeat (10) @(posedge clk);
		$display("covered %0d ticks and %0d checked results over %0d register settings",
			ticks_taken, results_checked, settings_run);
		$display("with %0d watchdog kicks and %0d lit LED ticks, %0d mismatches",
			kicks_seen, led_on_seen, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
